// ===== src/rsbd_pkg.sv =====
package rsbd_pkg;

    localparam int unsigned C_MAX_WIDTH  = 4096;
    localparam int unsigned C_MAX_HEIGHT = 4096;

    localparam logic [12:0] C_WIDTH_RESET  = 13'd720;
    localparam logic [12:0] C_HEIGHT_RESET = 13'd576;

    localparam logic [2:0] C_MAX_RESULTS = 3'd4;

    localparam logic C_REG_WIDTH  = 1'b0;
    localparam logic C_REG_HEIGHT = 1'b1;

    typedef enum logic {
        S_LOAD,
        S_DECODE
    } t_state;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } t_qitem;

    typedef struct packed {
        logic [23:0] bits;
        logic [4:0]  held;
        logic [12:0] col;
        logic [12:0] row;
        logic        fin;
    } t_dstate;

    typedef struct packed {
        logic        image_complete;
        logic        fill_rest;
        logic [1:0]  pixel_color;
        logic [12:0] run_length;
        logic [11:0] start_column;
        logic [11:0] line_index;
    } t_result;

    typedef struct packed {
        logic    valid;
        logic    last;
        t_result res;
    } t_push;

    function automatic logic [12:0] f_eff_dim(input logic [12:0] v, input int unsigned maxv);
        logic [12:0] r;
        if (v == 13'd0) begin
            r = 13'd1;
        end else if (32'(v) > maxv) begin
            r = 13'(maxv);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== src/rsbd_front.sv =====
module rsbd_front
    import rsbd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_qitem i_item,
    output logic   o_q_valid,
    output t_qitem o_q_item,
    input  logic   i_pop
);

    localparam int unsigned DEPTH = 4;

    t_qitem      r_mem [DEPTH];
    logic [1:0]  r_wr_ptr;
    logic [1:0]  r_rd_ptr;
    logic [2:0]  r_count;
    logic        w_push;
    logic        w_pop;

    assign o_ready   = (r_count != 3'(DEPTH));
    assign o_q_valid = (r_count != 3'd0);
    assign o_q_item  = r_mem[r_rd_ptr];
    assign w_push    = i_valid && o_ready;
    assign w_pop     = i_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 2'd1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= r_count + 3'(w_push) - 3'(w_pop);
        end
    end

endmodule

// ===== src/rsbd_back.sv =====
module rsbd_back
    import rsbd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [12:0] i_width,
    input  logic [12:0] i_height,
    input  logic        i_q_valid,
    input  t_qitem      i_q_item,
    output logic        o_pop,
    input  logic        i_out_free,
    output t_push       o_push
);

    t_state      r_state;
    t_state      n_state;
    t_dstate     r_st;
    t_dstate     n_st;
    logic [2:0]  r_cnt;
    logic [2:0]  n_cnt;
    logic        r_last;
    logic        n_last;
    logic        r_hold_v;
    logic        n_hold_v;
    t_result     r_hold;
    t_result     n_hold;

    logic [23:0] w_aligned;
    logic [15:0] w_win;
    logic [4:0]  w_size;
    logic [15:0] w_code;
    logic [13:0] w_run;
    logic [12:0] w_rem;
    logic [12:0] w_run_c;
    logic        w_dec_ok;
    logic        w_fill_ok;
    logic        w_stall;
    logic        w_can_load;
    t_dstate     w_load_st;
    t_dstate     w_dec_st;
    t_result     w_dec_res;
    t_result     w_fill_res;

    function automatic logic [23:0] f_mask(input logic [23:0] bits, input logic [4:0] held);
        logic [24:0] m;
        m = (25'd1 << held) - 25'd1;
        return bits & m[23:0];
    endfunction

    function automatic t_dstate f_end_row(input t_dstate s, input logic [12:0] h);
        t_dstate r;
        r      = s;
        r.held = {s.held[4:3], 3'b000};
        r.bits = f_mask(s.bits, r.held);
        r.col  = 13'd0;
        r.row  = s.row + 13'd1;
        if (r.row >= h) begin
            r.fin  = 1'b1;
            r.bits = 24'd0;
            r.held = 5'd0;
        end
        return r;
    endfunction

    function automatic logic [11:0] f_line(input logic [12:0] row, input logic [12:0] h);
        logic [13:0] half_w;
        logic [12:0] half;
        logic [12:0] diff;
        half_w = (14'(h) + 14'd1) >> 1;
        half   = half_w[12:0];
        diff   = row - half;
        return (row < half) ? {row[10:0], 1'b0} : {diff[10:0], 1'b1};
    endfunction

    // The code is left-aligned so that its leading bit pairs sit at fixed places.
    assign w_aligned = r_st.bits << (5'd24 - r_st.held);
    assign w_win     = w_aligned[23:8];

    always_comb begin
        priority if (r_st.held < 5'd2) begin
            w_size = 5'd0;
        end else if (w_win[15:14] != 2'd0) begin
            w_size = 5'd4;
        end else if (r_st.held < 5'd4) begin
            w_size = 5'd0;
        end else if (w_win[13:12] != 2'd0) begin
            w_size = 5'd8;
        end else if (r_st.held < 5'd6) begin
            w_size = 5'd0;
        end else if (w_win[11:10] != 2'd0) begin
            w_size = 5'd12;
        end else begin
            w_size = 5'd16;
        end
    end

    assign w_code = w_win >> (5'd16 - w_size);
    assign w_run  = w_code[15:2];
    assign w_rem  = i_width - r_st.col;

    always_comb begin
        if (w_run > 14'(w_rem)) begin
            w_run_c = w_rem;
        end else begin
            w_run_c = w_run[12:0];
        end
        if (w_run_c == 13'd0) begin
            w_run_c = w_rem;
        end
    end

    assign w_dec_ok   = !r_st.fin && (r_cnt != C_MAX_RESULTS) && (w_size != 5'd0)
                        && (r_st.held >= w_size);
    assign w_fill_ok  = r_last && !r_st.fin && (r_cnt != C_MAX_RESULTS);
    assign w_stall    = r_hold_v && !i_out_free;
    assign w_can_load = !r_hold_v || i_out_free;

    always_comb begin
        w_load_st = r_st;
        if (!r_st.fin) begin
            if (r_st.row >= i_height) begin
                w_load_st.fin  = 1'b1;
                w_load_st.bits = 24'd0;
                w_load_st.held = 5'd0;
            end else if (r_st.col >= i_width) begin
                w_load_st = f_end_row(r_st, i_height);
            end
        end
        if (!w_load_st.fin) begin
            w_load_st.bits = {w_load_st.bits[15:0], i_q_item.data};
            w_load_st.held = w_load_st.held + 5'd8;
        end
    end

    always_comb begin
        w_dec_st      = r_st;
        w_dec_st.held = r_st.held - w_size;
        w_dec_st.bits = f_mask(r_st.bits, w_dec_st.held);
        w_dec_st.col  = r_st.col + w_run_c;
        if (w_dec_st.col >= i_width) begin
            w_dec_st = f_end_row(w_dec_st, i_height);
        end
        w_dec_res.line_index     = f_line(r_st.row, i_height);
        w_dec_res.start_column   = r_st.col[11:0];
        w_dec_res.run_length     = w_run_c;
        w_dec_res.pixel_color    = w_code[1:0];
        w_dec_res.fill_rest      = 1'b0;
        w_dec_res.image_complete = w_dec_st.fin;
    end

    always_comb begin
        w_fill_res.line_index     = f_line(r_st.row, i_height);
        w_fill_res.start_column   = r_st.col[11:0];
        w_fill_res.run_length     = 13'd0;
        w_fill_res.pixel_color    = 2'd0;
        w_fill_res.fill_rest      = 1'b1;
        w_fill_res.image_complete = 1'b1;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (w_can_load && i_q_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!w_dec_ok && !(w_fill_ok && w_stall)) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_comb begin
        n_st     = r_st;
        n_cnt    = r_cnt;
        n_last   = r_last;
        n_hold_v = r_hold_v;
        n_hold   = r_hold;
        o_pop    = 1'b0;
        o_push   = '{valid: 1'b0, last: 1'b0, res: r_hold};
        unique case (r_state)
            S_LOAD: begin
                if (r_hold_v && i_out_free) begin
                    o_push.valid = 1'b1;
                    o_push.last  = 1'b1;
                    n_hold_v     = 1'b0;
                end
                if (w_can_load && i_q_valid) begin
                    o_pop  = 1'b1;
                    n_st   = w_load_st;
                    n_cnt  = 3'd0;
                    n_last = i_q_item.last;
                end
            end
            S_DECODE: begin
                if (w_dec_ok) begin
                    if (!w_stall) begin
                        o_push.valid = r_hold_v;
                        n_hold_v     = 1'b1;
                        n_hold       = w_dec_res;
                        n_st         = w_dec_st;
                        n_cnt        = r_cnt + 3'd1;
                    end
                end else if (!(w_fill_ok && w_stall)) begin
                    if (w_fill_ok) begin
                        o_push.valid = r_hold_v;
                        n_hold_v     = 1'b1;
                        n_hold       = w_fill_res;
                    end
                    if (r_last) begin
                        n_st = '0;
                    end
                end
            end
            default: begin
                n_st = r_st;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_st     <= '0;
            r_cnt    <= 3'd0;
            r_last   <= 1'b0;
            r_hold_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_st     <= n_st;
            r_cnt    <= n_cnt;
            r_last   <= n_last;
            r_hold_v <= n_hold_v;
        end
    end

endmodule

// ===== src/rle_subtitle_bitmap_decoder_core.sv =====
// Decodes the 2-bit run-length pixel data of a subtitle bitmap, one coded byte per request on
// the slave stream, and emits one run per request on the master stream with its interlaced
// output line, start column, clipped length and colour. Each byte is loaded, then the single
// decode path retires one code per cycle while the output is free. A four-entry input queue
// and an output register let both streams stall independently. The final byte of a packet
// adds a fill request covering the rest of the image with colour 0 unless the image is done
// or the byte gave four runs, and restarts the decoder. The user must write image width and
// height through the configuration port only while idle; the block does not enforce it.
module rle_subtitle_bitmap_decoder_core
    import rsbd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [11:0] line_index, [23:12] start_column,
                                        // [36:24] run_length, [38:37] pixel_color, [39] zero
    output logic [1:0]  m_axis_tuser,   // [0] fill_rest, [1] image_complete
    output logic        m_axis_tlast
);

    logic [12:0] r_width;
    logic [12:0] r_height;
    logic [12:0] w_width;
    logic [12:0] w_height;
    logic        w_q_valid;
    t_qitem      w_q_item;
    logic        w_pop;
    logic        w_out_free;
    t_push       w_push;
    logic        r_out_v;
    t_result     r_out;
    logic        r_out_last;

    assign o_cfg_ready = 1'b1;
    assign w_width     = f_eff_dim(r_width, C_MAX_WIDTH);
    assign w_height    = f_eff_dim(r_height, C_MAX_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= C_WIDTH_RESET;
            r_height <= C_HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                C_REG_WIDTH:  r_width  <= i_cfg_data;
                C_REG_HEIGHT: r_height <= i_cfg_data;
                default:      r_width  <= r_width;
            endcase
        end
    end

    rsbd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    ('{last: s_axis_tlast, data: s_axis_tdata}),
        .o_q_valid (w_q_valid),
        .o_q_item  (w_q_item),
        .i_pop     (w_pop)
    );

    rsbd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_width    (w_width),
        .i_height   (w_height),
        .i_q_valid  (w_q_valid),
        .i_q_item   (w_q_item),
        .o_pop      (w_pop),
        .i_out_free (w_out_free),
        .o_push     (w_push)
    );

    assign w_out_free = !r_out_v || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (w_push.valid) begin
            r_out      <= w_push.res;
            r_out_last <= w_push.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_push.valid) begin
            r_out_v <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_v <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {1'b0, r_out.pixel_color, r_out.run_length, r_out.start_column,
                            r_out.line_index};
    assign m_axis_tuser  = {r_out.image_complete, r_out.fill_rest};
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== src/rsbd_checker.sv =====
module rsbd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("Stalled result changed.");

    a_fill_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[36:24] == 13'd0
            && m_axis_tdata[38:37] == 2'd0 && m_axis_tuser[1] && m_axis_tlast)
        else $error("Fill result is not a closing result.");

    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[36:24] != 13'd0)
        else $error("Decoded run has zero length.");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("Result shown right after reset.");

endmodule

bind rle_subtitle_bitmap_decoder_core rsbd_checker u_rsbd_checker (.*);

// ===== sim/rsbd_run_checker.sv =====
module rsbd_run_checker
    import rsbd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] stream_byte
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,    // [11:0] line_index, [23:12] start_column,
                                      // [36:24] run_length, [38:37] pixel_color, [39] zero
    input  logic [1:0]  i_m_tuser,    // [0] fill_rest, [1] image_complete
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_runs_checked,
    output int          o_fills_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_result res;
        logic    lst;
    } t_run_due;

    t_run_due    runs_due[$];
    logic [12:0] reg_w = C_WIDTH_RESET;
    logic [12:0] reg_h = C_HEIGHT_RESET;
    logic [23:0] buf_bits = '0;
    int unsigned held = 0;
    int unsigned col = 0;
    int unsigned row = 0;
    logic        img_done = 1'b0;
    int          fail_cnt = 0;
    int          due_cnt = 0;
    int          runs_cnt = 0;
    int          fills_cnt = 0;

    assign o_fail_count    = fail_cnt;
    assign o_pending       = due_cnt;
    assign o_runs_checked  = runs_cnt;
    assign o_fills_checked = fills_cnt;

    function automatic int unsigned clamp_dim(input logic [12:0] v, input int unsigned maxv);
        if (v == 13'd0) begin
            return 1;
        end
        return (int'(v) > maxv) ? maxv : int'(v);
    endfunction

    function automatic int unsigned out_line(input int unsigned r, input int unsigned h);
        int unsigned half;
        half = (h + 1) / 2;
        return (r < half) ? 2 * r : 2 * (r - half) + 1;
    endfunction

    function automatic int unsigned keep_mask(input int unsigned n);
        return (32'd1 << n) - 32'd1;
    endfunction

    // Size of the code at the head of the buffer, or zero while still unknown.
    function automatic int unsigned head_code_bits();
        int unsigned need;
        for (int p = 0; p < 3; p++) begin
            need = 2 * (p + 1);
            if (held < need) begin
                return 0;
            end
            if (((32'(buf_bits) >> (held - need)) & 32'd3) != 0) begin
                return 4 * (p + 1);
            end
        end
        return 16;
    endfunction

    task automatic close_row(input int unsigned h);
        held = held - (held & 7);
        buf_bits = buf_bits & 24'(keep_mask(held));
        col = 0;
        row++;
        if (row >= h) begin
            img_done = 1'b1;
            buf_bits = '0;
            held = 0;
        end
    endtask

    task automatic clear_decode();
        buf_bits = '0;
        held = 0;
        col = 0;
        row = 0;
        img_done = 1'b0;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic pkt_end);
        int unsigned w, h, len, code, run, rem;
        int          n;
        t_result     r;
        t_result     burst[4];
        w = clamp_dim(reg_w, C_MAX_WIDTH);
        h = clamp_dim(reg_h, C_MAX_HEIGHT);
        n = 0;
        if (!img_done) begin
            if (row >= h) begin
                img_done = 1'b1;
                buf_bits = '0;
                held = 0;
            end else if (col >= w) begin
                close_row(h);
            end
        end
        if (!img_done) begin
            buf_bits = {buf_bits[15:0], b};
            held += 8;
            while (!img_done && n < int'(C_MAX_RESULTS)) begin
                len = head_code_bits();
                if (len == 0 || held < len) begin
                    break;
                end
                code = (32'(buf_bits) >> (held - len)) & keep_mask(len);
                held -= len;
                buf_bits = buf_bits & 24'(keep_mask(held));
                run = code >> 2;
                rem = w - col;
                if (run > rem) begin
                    run = rem;
                end
                if (run == 0) begin
                    run = rem;
                end
                r = '0;
                r.line_index   = 12'(out_line(row, h));
                r.start_column = 12'(col);
                r.run_length   = 13'(run);
                r.pixel_color  = 2'(code);
                col += run;
                if (col >= w) begin
                    close_row(h);
                    r.image_complete = img_done;
                end
                burst[n] = r;
                n++;
            end
        end
        if (pkt_end) begin
            if (!img_done && n < int'(C_MAX_RESULTS)) begin
                r = '0;
                r.line_index     = 12'(out_line(row, h));
                r.start_column   = 12'(col);
                r.fill_rest      = 1'b1;
                r.image_complete = 1'b1;
                burst[n] = r;
                n++;
            end
            clear_decode();
        end
        for (int i = 0; i < n; i++) begin
            runs_due.push_back('{res: burst[i], lst: logic'(i == n - 1)});
        end
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        fail_cnt++;
        if (fail_cnt <= 40) begin
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        end
    endtask

    task automatic check_run();
        t_result  seen;
        t_run_due due;
        seen = t_result'({i_m_tuser, i_m_tdata[38:0]});
        if (runs_due.size() == 0) begin
            report_mismatch("run with nothing due", 1, 0);
            return;
        end
        due = runs_due.pop_front();
        runs_cnt++;
        if (due.res.fill_rest) begin
            fills_cnt++;
        end
        if (seen.line_index !== due.res.line_index) begin
            report_mismatch("line_index", seen.line_index, due.res.line_index);
        end
        if (seen.start_column !== due.res.start_column) begin
            report_mismatch("start_column", seen.start_column, due.res.start_column);
        end
        if (seen.run_length !== due.res.run_length) begin
            report_mismatch("run_length", seen.run_length, due.res.run_length);
        end
        if (seen.pixel_color !== due.res.pixel_color) begin
            report_mismatch("pixel_color", seen.pixel_color, due.res.pixel_color);
        end
        if (seen.fill_rest !== due.res.fill_rest) begin
            report_mismatch("fill_rest", seen.fill_rest, due.res.fill_rest);
        end
        if (seen.image_complete !== due.res.image_complete) begin
            report_mismatch("image_complete", seen.image_complete, due.res.image_complete);
        end
        if (i_m_tlast !== due.lst) begin
            report_mismatch("last_of_burst", i_m_tlast, due.lst);
        end
        if (i_m_tdata[39] !== 1'b0) begin
            report_mismatch("tdata pad bit", i_m_tdata[39], 0);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reg_w = C_WIDTH_RESET;
            reg_h = C_HEIGHT_RESET;
            clear_decode();
            runs_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == C_REG_WIDTH) begin
                    reg_w = i_cfg_data;
                end else begin
                    reg_h = i_cfg_data;
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                check_run();
            end
            if (i_s_tvalid && i_s_tready) begin
                decode_byte(i_s_tdata, i_s_tlast);
            end
        end
        due_cnt = runs_due.size();
    end

endmodule

// ===== sim/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rsbd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 32;
    localparam int BYTE_TARGET    = 230;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = C_REG_WIDTH;
    logic [12:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int fail_count;
    int pending;
    int runs_checked;
    int fills_checked;

    logic        quiet = 1'b0;
    logic        hold_midway = 1'b0;
    logic        enc_bits[$];
    int unsigned cur_w = int'(C_WIDTH_RESET);
    int unsigned cur_h = int'(C_HEIGHT_RESET);
    int          bytes_sent = 0;
    int          packets = 0;
    int          settings = 0;
    int          idle_cycles = 0;

    rle_subtitle_bitmap_decoder_core dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    rsbd_run_checker run_chk (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_tvalid      (s_axis_tvalid),
        .i_s_tready      (s_axis_tready),
        .i_s_tdata       (s_axis_tdata),
        .i_s_tlast       (s_axis_tlast),
        .i_m_tvalid      (m_axis_tvalid),
        .i_m_tready      (m_axis_tready),
        .i_m_tdata       (m_axis_tdata),
        .i_m_tuser       (m_axis_tuser),
        .i_m_tlast       (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_runs_checked  (runs_checked),
        .o_fills_checked (fills_checked)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk) begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 6);
    end

    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready) || !rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int unsigned active_dim(input logic [12:0] v);
        if (v == 13'd0) begin
            return 1;
        end
        return (int'(v) > C_MAX_WIDTH) ? C_MAX_WIDTH : int'(v);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic pkt_end);
        @(negedge clk);
        while (!quiet && $urandom_range(99) < 6) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= pkt_end;
        do @(posedge clk); while (!s_axis_tready);
        bytes_sent++;
        if (pkt_end) begin
            packets++;
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
    endtask

    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [12:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == C_REG_WIDTH) begin
            cur_w = active_dim(val);
        end else begin
            cur_h = active_dim(val);
        end
    endtask

    task automatic set_dims(input logic [12:0] w, input logic [12:0] h);
        settle();
        write_reg(C_REG_WIDTH, w);
        write_reg(C_REG_HEIGHT, h);
        settings++;
    endtask

    // A size of zero picks the shortest code that can carry the run.
    task automatic put_code(input int unsigned run, input int unsigned color,
                            input int unsigned size);
        logic [15:0] word;
        int unsigned sz;
        word = 16'((run << 2) | color);
        sz = size;
        if (sz == 0) begin
            sz = (run == 0 || run > 63) ? 16 : (run > 15) ? 12 : (run > 3) ? 8 : 4;
        end
        for (int i = int'(sz) - 1; i >= 0; i--) begin
            enc_bits.push_back(word[i]);
        end
    endtask

    task automatic pad_to_byte();
        while (enc_bits.size() % 8 != 0) begin
            enc_bits.push_back(1'($urandom_range(1)));
        end
    endtask

    task automatic flush_bytes(input logic pkt_end);
        logic [7:0] b;
        int         nbytes;
        nbytes = enc_bits.size() / 8;
        if (nbytes == 0 && pkt_end) begin
            send_byte(8'($urandom), 1'b1);
        end
        for (int k = 0; k < nbytes; k++) begin
            for (int i = 0; i < 8; i++) begin
                b[7 - i] = enc_bits.pop_front();
            end
            if (hold_midway && k == nbytes / 2) begin
                wait_drained();
                hold_midway = 1'b0;
            end
            send_byte(b, pkt_end && k == nbytes - 1);
        end
    endtask

    // Mostly fits the row; some runs fill the row or overshoot it and get clipped.
    task automatic encode_row(input int max_codes);
        int unsigned c, rem, lim, run, pick;
        int          codes;
        c = 0;
        codes = 0;
        while (c < cur_w && (max_codes == 0 || codes < max_codes)) begin
            rem = cur_w - c;
            pick = $urandom_range(99);
            if (pick < 8) begin
                run = 0;
            end else if (pick < 16) begin
                run = rem + $urandom_range(8, 1);
                if (run > 255) begin
                    run = 255;
                end
            end else begin
                case ($urandom_range(3))
                    0: begin
                        lim = 3;
                    end
                    1: begin
                        lim = 15;
                    end
                    2: begin
                        lim = 63;
                    end
                    default: begin
                        lim = 255;
                    end
                endcase
                if (lim > rem) begin
                    lim = rem;
                end
                run = $urandom_range(lim, 1);
            end
            put_code(run, $urandom_range(3), ($urandom_range(99) < 15) ? 16 : 0);
            c = (run == 0 || run >= rem) ? cur_w : c + run;
            codes++;
        end
        pad_to_byte();
    endtask

    task automatic send_image(input int rows, input logic cut, input logic tail,
                              input logic pkt_end);
        for (int r = 0; r < rows; r++) begin
            encode_row((cut && r == rows - 1) ? int'($urandom_range(3, 1)) : 0);
        end
        if (tail) begin
            repeat ($urandom_range(24, 8)) enc_bits.push_back(1'($urandom_range(1)));
        end
        pad_to_byte();
        flush_bytes(pkt_end);
    endtask

    initial begin : stimulus
        logic [12:0] wv;
        logic [12:0] hv;
        logic        cut;
        int          rows;
        int          pkt;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset dimensions: all code sizes, a row fill and a packet-end fill.
        send_byte(8'h5F, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        put_code(40, 2, 0);
        put_code(200, 1, 0);
        put_code(0, 3, 0);
        pad_to_byte();
        put_code(3, 0, 0);
        pad_to_byte();
        flush_bytes(1'b1);

        // Zero dimensions act as a single pixel; bytes after completion are ignored.
        set_dims(13'd0, 13'd0);
        send_byte(8'h40, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hAA, 1'b1);

        // Oversized dimensions clamp to the maximum; a zero run spans the full row.
        set_dims(13'h1FFF, 13'h1FFF);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b1);

        // Clipping at the row end and the odd-line half of the interlace.
        set_dims(13'd5, 13'd3);
        put_code(7, 1, 0);
        pad_to_byte();
        put_code(3, 1, 0);
        put_code(2, 2, 0);
        pad_to_byte();
        put_code(1, 3, 16);
        pad_to_byte();
        flush_bytes(1'b1);

        pkt = 0;
        while (bytes_sent < BYTE_TARGET) begin
            quiet = (pkt >= 4 && pkt < 8);
            hold_midway = (pkt == 2);
            if (pkt == 0 || $urandom_range(99) < 40) begin
                if ($urandom_range(99) < 15) begin
                    case ($urandom_range(3))
                        0: begin
                            wv = 13'd0;
                        end
                        1: begin
                            wv = 13'd4096;
                        end
                        2: begin
                            wv = 13'h1FFF;
                        end
                        default: begin
                            wv = 13'($urandom);
                        end
                    endcase
                    hv = ($urandom_range(1) == 0) ? 13'($urandom) : 13'($urandom_range(6, 1));
                end else begin
                    wv = 13'($urandom_range(32, 1));
                    hv = 13'($urandom_range(6, 1));
                end
                set_dims(wv, hv);
            end
            if (pkt == 6) begin
                // Dimensions shrink while an image is half decoded.
                set_dims(13'd14, 13'd6);
                send_image(3, 1'b1, 1'b0, 1'b0);
                set_dims(13'd1, 13'd6);
                send_byte(8'($urandom), 1'b0);
                set_dims(13'd3, 13'd1);
                send_byte(8'($urandom), 1'b0);
                send_byte(8'($urandom), 1'b1);
            end else if ($urandom_range(99) < 15) begin
                repeat ($urandom_range(5)) send_byte(8'($urandom), 1'b0);
                send_byte(8'($urandom), 1'b1);
            end else begin
                cut = ($urandom_range(99) < 20);
                rows = cur_h;
                if (cur_w > 300) begin
                    rows = 1;
                    cut = 1'b1;
                end else if (cur_h > 8) begin
                    rows = $urandom_range(3, 1);
                    cut = 1'b1;
                end else if (cut) begin
                    rows = $urandom_range(cur_h, 1);
                end
                send_image(rows, cut, $urandom_range(99) < 25, 1'b1);
            end
            pkt++;
        end
        quiet = 1'b0;

        settle();
        $display("Run covered %0d coded bytes in %0d packets over %0d dimension settings.",
                 bytes_sent, packets, settings);
        $display("Compared %0d runs against the prediction, %0d of them packet-end fills.",
                 runs_checked, fills_checked);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/rsbd_pkg.sv
src/rsbd_front.sv
src/rsbd_back.sv
src/rle_subtitle_bitmap_decoder_core.sv
src/rsbd_checker.sv
sim/rsbd_run_checker.sv
sim/tb.sv
